FILE: rtl/hvd_pkg.sv
// Shared constants, types and helpers for the haversine distance pipeline.
package hvd_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 23;
  localparam int CORDIC_STAGES_DEF   = 24;

  // Root bits: a is at most 2^30, radicand (a << 30) fits 62 bits.
  localparam int SQRT_BITS = 31;
  localparam int FOLD_LAT  = 4;
  // diff stage + fold + three product/clamp stages + root + two output stages
  localparam int FIXED_LAT = 1 + FOLD_LAT + 3 + SQRT_BITS + 2;

  localparam int RADIUS_W = 23;
  localparam int DIST_W   = 33;

  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic [26:0]        DEG2RAD_Q32     = 27'd74961321;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 23'd6371000;
  localparam logic [30:0]        Q30_ONE         = 31'h4000_0000;

  // Reciprocal of 360 for the modulo in the angle fold.
  localparam int RECIP_SH = 24;

  localparam logic signed [31:0] ATAN_Q30 [32] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128,
    32'sd64,        32'sd32,        32'sd16,        32'sd8,
    32'sd4,         32'sd2,         32'sd1,         32'sd0
  };

  typedef enum logic {
    CORDIC_ROTATE,
    CORDIC_VECTOR
  } cordic_mode_t;

  typedef struct packed {
    logic valid;
    logic tag;
  } hvd_ctl_t;

  // Q30 product rounded half up.
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

endpackage

FILE: rtl/haversine_distance_top.sv
// Top level: fully pipelined haversine great-circle distance.
//
//  channel   signals                                        direction
//  request   start, busy, lat_now, lon_now, lat_before,     in (busy out)
//            lon_before
//  result    done, distance, clamped                        out
//  config    cfg_wr_en, cfg_wr_data (sphere radius, m)      in
//
// One request per cycle while busy is low; the path runs through the two
// CORDIC pipelines in series and the 31-stage square root.
// busy follows rst; after reset the pipeline is empty and done stays low
// until the first request comes out. done is a one-cycle strobe and the
// receiver cannot stall it.
module haversine_distance_top import hvd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [30:0]  lat_now,
  input  logic signed [31:0]  lon_now,
  input  logic signed [30:0]  lat_before,
  input  logic signed [31:0]  lon_before,
  input  logic                cfg_wr_en,
  input  logic [RADIUS_W-1:0] cfg_wr_data,
  output logic                done,
  output logic [DIST_W-1:0]   distance,
  output logic                clamped
);

  logic [RADIUS_W-1:0] radius;

  hvd_ctl_t           d_ctl;
  logic signed [31:0] dlat;
  logic signed [32:0] dlon;
  logic signed [30:0] latn_d, latb_d;

  hvd_ctl_t    f_ctl_dlat, f_ctl_dlon, f_ctl_latn, f_ctl_latb;
  logic [30:0] rad_dlat, rad_dlon, rad_latn, rad_latb;

  hvd_ctl_t           r_ctl_dlat, r_ctl_latn, r_ctl_latb;
  logic signed [31:0] sin_dlat, sin_dlon, cos_latn, cos_latb;
  logic signed [31:0] cos_a, cos_b;

  logic               m1_valid, m2_valid;
  logic signed [31:0] sl1, so1, cc1, sl2, t2;

  logic signed [32:0] asum;
  logic [30:0]        a_cl;
  logic               a_flag;
  hvd_ctl_t           a_ctl;
  logic [30:0]        a3, na3;

  hvd_ctl_t           s_ctl;
  logic [SQRT_BITS-1:0] ys, xs;

  hvd_ctl_t           v_ctl;
  logic signed [31:0] ang;
  logic [30:0]        ang_cl;

  logic                       p_valid, p_flag;
  logic [RADIUS_W+30:0]       prod;
  logic [RADIUS_W+30:0]       dsum;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  // differences
  always_ff @(posedge clk) begin
    dlat   <= 32'(lat_now) - 32'(lat_before);
    dlon   <= 33'(lon_now) - 33'(lon_before);
    latn_d <= lat_now;
    latb_d <= lat_before;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
    end else begin
      d_ctl <= '{valid: start && !busy, tag: 1'b0};
    end
  end

  // half differences carry one more fraction bit
  hvd_fold #(.IN_W(32), .FB(ANGLE_FRAC_BITS + 1)) u_fold_dlat (
    .clk(clk), .rst(rst), .in_ctl(d_ctl), .ang(dlat),
    .out_ctl(f_ctl_dlat), .rad(rad_dlat));
  hvd_fold #(.IN_W(33), .FB(ANGLE_FRAC_BITS + 1)) u_fold_dlon (
    .clk(clk), .rst(rst), .in_ctl(d_ctl), .ang(dlon),
    .out_ctl(f_ctl_dlon), .rad(rad_dlon));
  hvd_fold #(.IN_W(31), .FB(ANGLE_FRAC_BITS)) u_fold_latn (
    .clk(clk), .rst(rst), .in_ctl(d_ctl), .ang(latn_d),
    .out_ctl(f_ctl_latn), .rad(rad_latn));
  hvd_fold #(.IN_W(31), .FB(ANGLE_FRAC_BITS)) u_fold_latb (
    .clk(clk), .rst(rst), .in_ctl(d_ctl), .ang(latb_d),
    .out_ctl(f_ctl_latb), .rad(rad_latb));

  hvd_cordic #(.MODE(CORDIC_ROTATE), .STAGES(CORDIC_STAGES)) u_rot_dlat (
    .clk(clk), .rst(rst), .in_ctl(f_ctl_dlat),
    .x_in(CORDIC_GAIN_Q30), .y_in(32'sd0), .z_in(signed'({1'b0, rad_dlat})),
    .out_ctl(r_ctl_dlat), .x_out(), .y_out(sin_dlat), .z_out());
  hvd_cordic #(.MODE(CORDIC_ROTATE), .STAGES(CORDIC_STAGES)) u_rot_dlon (
    .clk(clk), .rst(rst), .in_ctl(f_ctl_dlon),
    .x_in(CORDIC_GAIN_Q30), .y_in(32'sd0), .z_in(signed'({1'b0, rad_dlon})),
    .out_ctl(), .x_out(), .y_out(sin_dlon), .z_out());
  hvd_cordic #(.MODE(CORDIC_ROTATE), .STAGES(CORDIC_STAGES)) u_rot_latn (
    .clk(clk), .rst(rst), .in_ctl(f_ctl_latn),
    .x_in(CORDIC_GAIN_Q30), .y_in(32'sd0), .z_in(signed'({1'b0, rad_latn})),
    .out_ctl(r_ctl_latn), .x_out(cos_latn), .y_out(), .z_out());
  hvd_cordic #(.MODE(CORDIC_ROTATE), .STAGES(CORDIC_STAGES)) u_rot_latb (
    .clk(clk), .rst(rst), .in_ctl(f_ctl_latb),
    .x_in(CORDIC_GAIN_Q30), .y_in(32'sd0), .z_in(signed'({1'b0, rad_latb})),
    .out_ctl(r_ctl_latb), .x_out(cos_latb), .y_out(), .z_out());

  // tag marks a fold past 90 degrees: negate the cosine
  assign cos_a = r_ctl_latn.tag ? -cos_latn : cos_latn;
  assign cos_b = r_ctl_latb.tag ? -cos_latb : cos_latb;

  always_ff @(posedge clk) begin
    sl1 <= mul_q30(sin_dlat, sin_dlat);
    so1 <= mul_q30(sin_dlon, sin_dlon);
    cc1 <= mul_q30(cos_a, cos_b);
    sl2 <= sl1;
    t2  <= mul_q30(so1, cc1);
  end

  always_comb begin
    asum   = 33'(sl2) + 33'(t2);
    a_flag = 1'b0;
    a_cl   = asum[30:0];
    if (asum[32]) begin
      a_cl   = '0;
      a_flag = 1'b1;
    end else if (asum > 33'(Q30_ONE)) begin
      a_cl   = Q30_ONE;
      a_flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a3  <= a_cl;
    na3 <= Q30_ONE - a_cl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      a_ctl    <= '0;
    end else begin
      m1_valid <= r_ctl_dlat.valid;
      m2_valid <= m1_valid;
      a_ctl    <= '{valid: m2_valid, tag: a_flag};
    end
  end

  hvd_sqrt #(.RB(SQRT_BITS)) u_sqrt_a (
    .clk(clk), .rst(rst), .in_ctl(a_ctl), .radicand({1'b0, a3, 30'd0}),
    .out_ctl(s_ctl), .root(ys));
  hvd_sqrt #(.RB(SQRT_BITS)) u_sqrt_na (
    .clk(clk), .rst(rst), .in_ctl(a_ctl), .radicand({1'b0, na3, 30'd0}),
    .out_ctl(), .root(xs));

  hvd_cordic #(.MODE(CORDIC_VECTOR), .STAGES(CORDIC_STAGES)) u_vec (
    .clk(clk), .rst(rst), .in_ctl(s_ctl),
    .x_in(signed'(32'(xs))), .y_in(signed'(32'(ys))), .z_in(32'sd0),
    .out_ctl(v_ctl), .x_out(), .y_out(), .z_out(ang));

  assign ang_cl = ang[31] ? '0 : ang[30:0];
  assign dsum   = prod + ((RADIUS_W+31)'(1) << 20);

  always_ff @(posedge clk) begin
    prod     <= (RADIUS_W+31)'(radius) * (RADIUS_W+31)'(ang_cl);
    p_flag   <= v_ctl.tag;
    distance <= dsum[21 +: DIST_W];
    clamped  <= p_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      p_valid <= v_ctl.valid;
      done    <= p_valid;
    end
  end

endmodule

FILE: rtl/hvd_fold.sv
// Angle fold into [0,90] degrees and conversion to Q30 radians.
module hvd_fold import hvd_pkg::*; #(
  parameter int IN_W = 32,
  parameter int FB   = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hvd_ctl_t               in_ctl,
  input  logic signed [IN_W-1:0] ang,
  output hvd_ctl_t               out_ctl,
  output logic [30:0]            rad
);

  localparam int INT_W = IN_W - FB;
  localparam int P_W   = INT_W + 16;
  localparam int M_W   = 9 + FB;
  localparam int D_W   = 7 + FB;
  localparam int R_W   = D_W + 27;
  localparam logic [15:0]    RECIP   = 16'((2**RECIP_SH + 359) / 360);
  localparam logic [M_W-1:0] FULL    = M_W'(360) << FB;
  localparam logic [M_W-1:0] HALF    = M_W'(180) << FB;
  localparam logic [M_W-1:0] QUARTER = M_W'(90) << FB;

  logic [IN_W-1:0]  mag;
  logic [P_W-1:0]   prod1;
  logic [INT_W-1:0] n1;
  logic [FB-1:0]    frac1;
  hvd_ctl_t         ctl1, ctl2, ctl3, ctl4;
  logic [P_W-1:0]   qv, rv;
  logic [M_W-1:0]   m0, m1, m2;
  logic [D_W-1:0]   m3;
  logic [R_W-1:0]   pr;

  assign mag = ang[IN_W-1] ? IN_W'(-ang) : IN_W'(ang);

  // integer degrees mod 360 by reciprocal multiply; exact for n below 2^16
  always_comb begin
    qv = prod1 >> RECIP_SH;
    rv = P_W'(n1) - qv * P_W'(360);
    m0 = {rv[8:0], frac1};
    m1 = (m0 > HALF) ? FULL - m0 : m0;
  end

  assign pr = R_W'(m3) * R_W'(DEG2RAD_Q32) + (R_W'(1) << (FB + 1));

  always_ff @(posedge clk) begin
    prod1 <= P_W'(mag[IN_W-1:FB]) * P_W'(RECIP);
    n1    <= mag[IN_W-1:FB];
    frac1 <= mag[FB-1:0];
    m2    <= m1;
    if (m2 > QUARTER) begin
      m3 <= D_W'(HALF - m2);
    end else begin
      m3 <= D_W'(m2);
    end
    rad <= pr[FB+2 +: 31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
    end else begin
      ctl1 <= '{valid: in_ctl.valid, tag: 1'b0};
      ctl2 <= ctl1;
      ctl3 <= '{valid: ctl2.valid, tag: (m2 > QUARTER)};
      ctl4 <= ctl3;
    end
  end

  assign out_ctl = ctl4;

endmodule

FILE: rtl/hvd_cordic.sv
// Pipelined CORDIC, one micro-rotation per register stage.
module hvd_cordic import hvd_pkg::*; #(
  parameter cordic_mode_t MODE   = CORDIC_ROTATE,
  parameter int           STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  hvd_ctl_t           in_ctl,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  output hvd_ctl_t           out_ctl,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out
);

  logic signed [31:0] xr [STAGES];
  logic signed [31:0] yr [STAGES];
  logic signed [31:0] zr [STAGES];
  hvd_ctl_t           cr [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam int K = i % 32;
    logic signed [31:0] xi, yi, zi, dx, dy;
    hvd_ctl_t           ci;
    logic               sub;

    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
      assign ci = in_ctl;
    end else begin : g_next
      assign xi = xr[i-1];
      assign yi = yr[i-1];
      assign zi = zr[i-1];
      assign ci = cr[i-1];
    end

    always_comb begin
      dx  = yi >>> K;
      dy  = xi >>> K;
      // rotate drives z to zero, vector drives y to zero
      sub = (MODE == CORDIC_ROTATE) ? !zi[31] : yi[31];
    end

    always_ff @(posedge clk) begin
      if (sub) begin
        xr[i] <= xi - dx;
        yr[i] <= yi + dy;
        zr[i] <= zi - ATAN_Q30[K];
      end else begin
        xr[i] <= xi + dx;
        yr[i] <= yi - dy;
        zr[i] <= zi + ATAN_Q30[K];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cr[i] <= '0;
      end else begin
        cr[i] <= ci;
      end
    end
  end

  assign x_out   = xr[STAGES-1];
  assign y_out   = yr[STAGES-1];
  assign z_out   = zr[STAGES-1];
  assign out_ctl = cr[STAGES-1];

endmodule

FILE: rtl/hvd_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module hvd_sqrt import hvd_pkg::*; #(
  parameter int RB = SQRT_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  hvd_ctl_t        in_ctl,
  input  logic [2*RB-1:0] radicand,
  output hvd_ctl_t        out_ctl,
  output logic [RB-1:0]   root
);

  logic [2*RB-1:0] rad_r  [RB-1];
  logic [RB:0]     rem_r  [RB];
  logic [RB-1:0]   root_r [RB];
  hvd_ctl_t        ctl_r  [RB];

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic [2*RB-1:0] rad_i;
    logic [RB:0]     rem_i;
    logic [RB-1:0]   root_i;
    hvd_ctl_t        ctl_i;
    logic [RB+2:0]   rem_sh, trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign rad_i  = radicand;
      assign rem_i  = '0;
      assign root_i = '0;
      assign ctl_i  = in_ctl;
    end else begin : g_next
      assign rad_i  = rad_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign root_i = root_r[i-1];
      assign ctl_i  = ctl_r[i-1];
    end

    always_comb begin
      rem_sh = {rem_i, rad_i[2*RB-1 -: 2]};
      trial  = {1'b0, root_i, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? (RB+1)'(rem_sh - trial) : (RB+1)'(rem_sh);
      root_r[i] <= {root_i[RB-2:0], ge};
    end

    if (i < RB - 1) begin : g_rad
      always_ff @(posedge clk) begin
        rad_r[i] <= rad_i << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_r[i] <= '0;
      end else begin
        ctl_r[i] <= ctl_i;
      end
    end
  end

  assign root    = root_r[RB-1];
  assign out_ctl = ctl_r[RB-1];

endmodule

FILE: rtl/hvd_checker.sv
// Port-level checks for the haversine distance pipeline, bound to the top.
module hvd_checker import hvd_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LAT = 2 * CORDIC_STAGES + FIXED_LAT;

  // every request comes out after the fixed latency
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request did not produce a result at the pipeline latency");

  // no result without a matching request
  a_done_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a request at the pipeline latency");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule

bind haversine_distance_top hvd_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_hvd_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done));
